// ===== hdl/etf_pkg.sv =====
// Shared types, constants and helpers for the escape-time fractal iterator.
package etf_pkg;

  // Fixed-point layout: input Q4.28 and internal values share 28 fraction bits
  localparam int FRAC_BITS = 28;
  localparam int IN_W      = 32;
  localparam int Z_W       = 34;   // partial powers and z, signed
  localparam int MAG_W     = 33;   // magnitude of a Z_W value
  localparam int MUL_W     = 32;   // shared multiplier operand width
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 66;   // signed sum of two products
  localparam int SH_W      = ACC_W - FRAC_BITS;
  localparam int IT_W      = 16;
  localparam int ORDER_W   = 4;
  localparam int PH_W      = 3;

  localparam logic [ORDER_W-1:0] MIN_ORDER = 4'd2;
  localparam logic [ORDER_W-1:0] MAX_ORDER = 4'd8;

  // Reset values of the configuration registers
  localparam logic [IT_W-1:0]    MAX_ITER_RST = 16'd1000;
  localparam logic [ORDER_W-1:0] ORDER_RST    = 4'd2;

  // A component at or above 2.0 escapes on its own
  localparam logic [MAG_W-1:0] ESC_MAG = 33'h0_2000_0000;
  // |z|^2 limit of 4.0 at 2*FRAC_BITS fraction bits
  localparam logic signed [ACC_W-1:0] ESC_SQ = 66'sh0_0400_0000_0000_0000;
  // A partial power component at magnitude 16.0 or beyond counts as escaped
  localparam logic signed [SH_W-1:0] BIG_POS = 38'sd4294967296;
  localparam logic signed [SH_W-1:0] BIG_NEG = -38'sd4294967296;

  typedef enum logic [1:0] {
    REG_MAX_ITER = 2'd0,
    REG_ORDER    = 2'd1,
    REG_MODE     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_MUL,
    ST_NARROW,
    ST_ADD,
    ST_SQ,
    ST_TEST,
    ST_FINISH
  } state_t;

  // Magnitude of a signed internal value
  function automatic logic [MAG_W-1:0] mag_z(input logic signed [Z_W-1:0] v);
    logic [Z_W-1:0] n;
    n = -v;
    return v[Z_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

// ===== hdl/etf_mul.sv =====
// Shared unsigned multiplier with a registered product.
module etf_mul (
  input  logic                         clk,
  input  logic [etf_pkg::MUL_W-1:0]    a,
  input  logic [etf_pkg::MUL_W-1:0]    b,
  output logic [etf_pkg::PROD_W-1:0]   p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hdl/escape_time_fractal_iterator.sv =====
// Escape-time fractal iterator: Mandelbrot / Burning Ship, order-n power.
// Each complex multiply runs on the one shared 32x32 multiplier.
// Throughput: one point at a time; the result register lets the next point
// start while a result waits. Reset (rst, synchronous) clears control state
// and sets max_iterations 1000, power_order 2, variant_mode 0.
module escape_time_fractal_iterator (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // [31:0] c_real, [63:32] c_imag
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // [15:0] iteration_count, [16] escaped, rest zero
);

  localparam int ZW = etf_pkg::Z_W;

  // Configuration registers
  logic [etf_pkg::IT_W-1:0]    max_iter;
  logic [etf_pkg::ORDER_W-1:0] order_reg;
  logic                        mode;
  logic [etf_pkg::ORDER_W-1:0] order_eff;

  etf_pkg::state_t state, state_next;

  // Datapath registers
  logic signed [ZW-1:0] cr, ci, zr, zi, br, bi, wr, wi;
  logic signed [etf_pkg::ACC_W-1:0] acc_re, acc_im;
  logic [etf_pkg::PH_W-1:0]    ph;
  logic [etf_pkg::ORDER_W-1:0] k;
  logic [etf_pkg::IT_W-1:0]    it;
  logic [etf_pkg::IT_W-1:0]    res_count;
  logic                        res_esc;
  logic                        prod_neg;

  // Combinational values
  logic [etf_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic                       mul_neg;
  logic [etf_pkg::PROD_W-1:0] prod;
  logic signed [etf_pkg::ACC_W-1:0] term;
  logic signed [etf_pkg::SH_W-1:0]  sh_re, sh_im;
  logic                       big;
  logic signed [ZW-1:0]       sum_re, sum_im;
  logic [etf_pkg::MAG_W-1:0]  sum_re_mag, sum_im_mag;
  logic                       add_esc;
  logic                       sq_esc;
  logic [etf_pkg::ORDER_W-1:0] k_inc;
  logic [etf_pkg::IT_W:0]     it_inc;
  logic                       out_free;
  logic [etf_pkg::MAG_W-1:0]  zr_mag, zi_mag, wr_mag, wi_mag, br_mag, bi_mag;
  logic signed [ZW-1:0]       cr_in, ci_in;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter  <= etf_pkg::MAX_ITER_RST;
      order_reg <= etf_pkg::ORDER_RST;
      mode      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        etf_pkg::REG_MAX_ITER: max_iter  <= cfg_data;
        etf_pkg::REG_ORDER:    order_reg <= cfg_data[etf_pkg::ORDER_W-1:0];
        etf_pkg::REG_MODE:     mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the exponent to the supported range
  always_comb begin
    if (order_reg < etf_pkg::MIN_ORDER) begin
      order_eff = etf_pkg::MIN_ORDER;
    end else if (order_reg > etf_pkg::MAX_ORDER) begin
      order_eff = etf_pkg::MAX_ORDER;
    end else begin
      order_eff = order_reg;
    end
  end

  // Sign-extend the Q4.28 input to the internal width
  assign cr_in = ZW'($signed(s_tdata[31:0]));
  assign ci_in = ZW'($signed(s_tdata[63:32]));

  assign zr_mag = etf_pkg::mag_z(zr);
  assign zi_mag = etf_pkg::mag_z(zi);
  assign wr_mag = etf_pkg::mag_z(wr);
  assign wi_mag = etf_pkg::mag_z(wi);
  assign br_mag = etf_pkg::mag_z(br);
  assign bi_mag = etf_pkg::mag_z(bi);

  // Shared multiplier
  etf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    prod_neg <= mul_neg;
  end

  // Signed term from the registered product
  assign term = prod_neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});

  // Drop fraction bits, rounding toward minus infinity
  assign sh_re = etf_pkg::SH_W'(acc_re >>> etf_pkg::FRAC_BITS);
  assign sh_im = etf_pkg::SH_W'(acc_im >>> etf_pkg::FRAC_BITS);
  assign big   = (sh_re >= etf_pkg::BIG_POS) || (sh_re <= etf_pkg::BIG_NEG) ||
                 (sh_im >= etf_pkg::BIG_POS) || (sh_im <= etf_pkg::BIG_NEG);

  // Add c and pre-test each component against 2.0
  assign sum_re     = wr + cr;
  assign sum_im     = wi + ci;
  assign sum_re_mag = etf_pkg::mag_z(sum_re);
  assign sum_im_mag = etf_pkg::mag_z(sum_im);
  assign add_esc    = (sum_re_mag >= etf_pkg::ESC_MAG) || (sum_im_mag >= etf_pkg::ESC_MAG);

  assign sq_esc   = acc_re >= etf_pkg::ESC_SQ;
  assign k_inc    = k + 4'd1;
  assign it_inc   = {1'b0, it} + 17'd1;
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      etf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (max_iter == '0) ? etf_pkg::ST_FINISH : etf_pkg::ST_BASE;
        end
      end
      etf_pkg::ST_BASE: state_next = etf_pkg::ST_MUL;
      etf_pkg::ST_MUL: begin
        if (ph == 3'd4) state_next = etf_pkg::ST_NARROW;
      end
      etf_pkg::ST_NARROW: begin
        priority if (big) state_next = etf_pkg::ST_FINISH;
        else if (k_inc < order_eff) state_next = etf_pkg::ST_MUL;
        else state_next = etf_pkg::ST_ADD;
      end
      etf_pkg::ST_ADD: state_next = add_esc ? etf_pkg::ST_FINISH : etf_pkg::ST_SQ;
      etf_pkg::ST_SQ: begin
        if (ph == 3'd2) state_next = etf_pkg::ST_TEST;
      end
      etf_pkg::ST_TEST: begin
        if (sq_esc || it_inc == {1'b0, max_iter}) begin
          state_next = etf_pkg::ST_FINISH;
        end else begin
          state_next = etf_pkg::ST_BASE;
        end
      end
      etf_pkg::ST_FINISH: begin
        if (out_free) state_next = etf_pkg::ST_IDLE;
      end
      default: state_next = etf_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and multiplier operand selection
  always_comb begin
    s_tready = (state == etf_pkg::ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    mul_neg  = 1'b0;
    unique case (state)
      etf_pkg::ST_MUL: begin
        unique case (ph)
          3'd0: begin
            mul_a   = wr_mag[etf_pkg::MUL_W-1:0];
            mul_b   = br_mag[etf_pkg::MUL_W-1:0];
            mul_neg = wr[ZW-1] ^ br[ZW-1];
          end
          3'd1: begin
            mul_a   = wi_mag[etf_pkg::MUL_W-1:0];
            mul_b   = bi_mag[etf_pkg::MUL_W-1:0];
            mul_neg = ~(wi[ZW-1] ^ bi[ZW-1]);
          end
          3'd2: begin
            mul_a   = wr_mag[etf_pkg::MUL_W-1:0];
            mul_b   = bi_mag[etf_pkg::MUL_W-1:0];
            mul_neg = wr[ZW-1] ^ bi[ZW-1];
          end
          3'd3: begin
            mul_a   = wi_mag[etf_pkg::MUL_W-1:0];
            mul_b   = br_mag[etf_pkg::MUL_W-1:0];
            mul_neg = wi[ZW-1] ^ br[ZW-1];
          end
          default: ;
        endcase
      end
      etf_pkg::ST_SQ: begin
        if (ph == 3'd0) begin
          mul_a = zr_mag[etf_pkg::MUL_W-1:0];
          mul_b = zr_mag[etf_pkg::MUL_W-1:0];
        end else begin
          mul_a = zi_mag[etf_pkg::MUL_W-1:0];
          mul_b = zi_mag[etf_pkg::MUL_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load, multiply-accumulate, narrow, add c, escape test
  always_ff @(posedge clk) begin
    unique case (state)
      etf_pkg::ST_IDLE: begin
        cr        <= cr_in;
        ci        <= ci_in;
        zr        <= cr_in;
        zi        <= ci_in;
        it        <= '0;
        res_count <= '0;
        res_esc   <= 1'b0;
      end
      etf_pkg::ST_BASE: begin
        // Burning Ship folds both components to their magnitudes
        br <= mode ? $signed({1'b0, zr_mag}) : zr;
        bi <= mode ? $signed({1'b0, zi_mag}) : zi;
        wr <= mode ? $signed({1'b0, zr_mag}) : zr;
        wi <= mode ? $signed({1'b0, zi_mag}) : zi;
        k  <= 4'd1;
        ph <= '0;
      end
      etf_pkg::ST_MUL: begin
        ph <= ph + 3'd1;
        unique case (ph)
          3'd1: acc_re <= term;
          3'd2: acc_re <= acc_re + term;
          3'd3: acc_im <= term;
          3'd4: acc_im <= acc_im + term;
          default: ;
        endcase
      end
      etf_pkg::ST_NARROW: begin
        wr <= sh_re[ZW-1:0];
        wi <= sh_im[ZW-1:0];
        k  <= k_inc;
        ph <= '0;
        if (big) begin
          res_count <= it;
          res_esc   <= 1'b1;
        end
      end
      etf_pkg::ST_ADD: begin
        zr <= sum_re;
        zi <= sum_im;
        ph <= '0;
        if (add_esc) begin
          res_count <= it;
          res_esc   <= 1'b1;
        end
      end
      etf_pkg::ST_SQ: begin
        ph <= ph + 3'd1;
        if (ph == 3'd1) begin
          acc_re <= term;
        end else if (ph == 3'd2) begin
          acc_re <= acc_re + term;
        end
      end
      etf_pkg::ST_TEST: begin
        it <= it_inc[etf_pkg::IT_W-1:0];
        if (sq_esc) begin
          res_count <= it;
          res_esc   <= 1'b1;
        end else begin
          res_count <= max_iter;
          res_esc   <= 1'b0;
        end
      end
      etf_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // Result register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == etf_pkg::ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == etf_pkg::ST_FINISH && out_free) begin
      m_tdata <= {7'b0, res_esc, res_count};
    end
  end

`ifndef SYNTH
  // An escaped point reports an index below the limit
  a_esc_below_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] < max_iter))
    else $error("escaped result not below iteration limit");

  // A point that stays bounded reports the limit itself
  a_inside_at_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[16]) |-> (m_tdata[15:0] == max_iter))
    else $error("bounded result differs from iteration limit");

  // Partial powers never run past the exponent
  a_power_index: assert property (@(posedge clk) disable iff (rst)
    (state == etf_pkg::ST_MUL) |-> (k < order_eff))
    else $error("partial power index beyond exponent");

  // The square test only sees components below 2.0
  a_square_range: assert property (@(posedge clk) disable iff (rst)
    (state == etf_pkg::ST_SQ) |-> (zr_mag < etf_pkg::ESC_MAG && zi_mag < etf_pkg::ESC_MAG))
    else $error("square test operand out of range");
`endif

endmodule
